### hw/rtl/macd_pkg.sv
// macd_pkg: field widths, register indexes, reset periods and sequencer types
// for the macd signal histogram block; no dependencies
`default_nettype none

package macd_pkg;

    localparam int PRICE_W     = 32;
    localparam int MACD_W      = 33;
    localparam int HIST_W      = 34;
    localparam int PERIOD_W    = 8;
    localparam int SUM_W       = 40;
    localparam int SIG_AVG_W   = 34;
    localparam int SIG_SUM_W   = 42;
    localparam int DIFF_W      = 35;
    localparam int ALPHA_W     = 25;
    localparam int ALPHA_SHIFT = 24;
    localparam int PROD_W      = 61;
    localparam int DIV_W       = 41;
    localparam int DIV_CNT_W   = 6;
    localparam int DEN_W       = 9;
    localparam int CFG_IDX_W   = 2;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t CFG_FAST_PERIOD   = 2'd0;
    localparam cfg_index_t CFG_SLOW_PERIOD   = 2'd1;
    localparam cfg_index_t CFG_SIGNAL_PERIOD = 2'd2;

    localparam logic [PERIOD_W-1:0] FAST_PERIOD_RESET   = 8'd12;
    localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RESET   = 8'd26;
    localparam logic [PERIOD_W-1:0] SIGNAL_PERIOD_RESET = 8'd9;

    // 2^25, numerator of the smoothing coefficient
    localparam logic [DIV_W-1:0] ALPHA_NUM = 41'h200_0000;

    typedef enum logic [1:0] {
        AVG_FAST   = 2'd0,
        AVG_SLOW   = 2'd1,
        AVG_SIGNAL = 2'd2
    } avg_sel_t;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SETUP  = 8'b0000_0010,
        ST_DIV    = 8'b0000_0100,
        ST_DIVEND = 8'b0000_1000,
        ST_MUL    = 8'b0001_0000,
        ST_ADD    = 8'b0010_0000,
        ST_NEXT   = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/macd_channels.sv
// macd_bar_if and macd_result_if: valid/ready channels for bar requests
// and histogram results; depends on macd_pkg
`default_nettype none

interface macd_bar_if;
    logic                          valid;
    logic                          ready;
    logic [macd_pkg::PRICE_W-1:0]  close_price;
    logic                          series_start;

    modport source (output valid, output close_price, output series_start, input ready);
    modport sink   (input valid, input close_price, input series_start, output ready);
endinterface

interface macd_result_if;
    logic                                valid;
    logic                                ready;
    logic                                macd_valid;
    logic signed [macd_pkg::MACD_W-1:0]  macd_value;
    logic                                signal_valid;
    logic signed [macd_pkg::MACD_W-1:0]  signal_value;
    logic signed [macd_pkg::HIST_W-1:0]  histogram_value;

    modport source (output valid, output macd_valid, output macd_value,
                    output signal_valid, output signal_value,
                    output histogram_value, input ready);
    modport sink   (input valid, input macd_valid, input macd_value,
                    input signal_valid, input signal_value,
                    input histogram_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/macd_signal_histogram.sv
// macd_signal_histogram: fast, slow and signal averages sharing one multiplier
// and one bit-serial divider; depends on macd_pkg and macd_channels
// sequence: each bar passes through setup, multiply, add and next for every average that updates
//   with a cached coefficient, then fin; a result held by the sink stalls the next request
// a seed division or coefficient refresh also passes through the divider states div and divend
// reset: periods 12/26/9, all averages, sums and counts zero, no coefficient cached
`default_nettype none

module macd_signal_histogram #(
    parameter int PERIOD_MAX = 255
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [macd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [macd_pkg::PERIOD_W-1:0]  cfg_data,
    macd_bar_if.sink                            bar,
    macd_result_if.source                       result
);

    localparam int CNT_W = $clog2(PERIOD_MAX + 1);
    localparam int CMP_W = (CNT_W > macd_pkg::PERIOD_W) ? CNT_W : macd_pkg::PERIOD_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(PERIOD_MAX);

    logic [macd_pkg::PERIOD_W-1:0]       fast_period_reg;
    logic [macd_pkg::PERIOD_W-1:0]       slow_period_reg;
    logic [macd_pkg::PERIOD_W-1:0]       signal_period_reg;

    macd_pkg::state_t                    state_reg;
    macd_pkg::state_t                    state_next;
    macd_pkg::avg_sel_t                  sel_reg;

    logic [macd_pkg::PRICE_W-1:0]        close_reg;
    logic [macd_pkg::PRICE_W-1:0]        fast_avg_reg;
    logic [macd_pkg::PRICE_W-1:0]        slow_avg_reg;
    logic [macd_pkg::SUM_W-1:0]          fast_sum_reg;
    logic [macd_pkg::SUM_W-1:0]          slow_sum_reg;
    logic signed [macd_pkg::SIG_AVG_W-1:0] sig_avg_reg;
    logic signed [macd_pkg::SIG_SUM_W-1:0] sig_sum_reg;
    logic [CNT_W-1:0]                    bar_cnt_reg;
    logic [CNT_W-1:0]                    bar_old_reg;
    logic [CNT_W-1:0]                    macd_cnt_reg;
    logic signed [macd_pkg::MACD_W-1:0]  macd_reg;
    logic                                fast_ok_reg;
    logic                                slow_ok_reg;
    logic                                sig_ok_reg;

    logic [macd_pkg::ALPHA_W-1:0]        alpha_reg [3];
    logic [macd_pkg::PERIOD_W-1:0]       alpha_period_reg [3];
    logic [2:0]                          alpha_ok_reg;

    logic [macd_pkg::DIV_W-1:0]          div_num_reg;
    logic [macd_pkg::DEN_W-1:0]          div_den_reg;
    logic [macd_pkg::DEN_W-1:0]          div_rem_reg;
    logic [macd_pkg::DIV_CNT_W-1:0]      div_cnt_reg;
    logic                                div_alpha_reg;
    logic                                div_neg_reg;

    logic signed [macd_pkg::PROD_W-1:0]  prod_reg;

    logic                                out_valid_reg;
    logic                                out_macd_valid_reg;
    logic signed [macd_pkg::MACD_W-1:0]  out_macd_reg;
    logic                                out_signal_valid_reg;
    logic signed [macd_pkg::MACD_W-1:0]  out_signal_reg;
    logic signed [macd_pkg::HIST_W-1:0]  out_hist_reg;

    // operands of the average selected by sel_reg
    logic [1:0]                          sel_idx;
    logic [macd_pkg::PERIOD_W-1:0]       p_cur;
    logic [CNT_W-1:0]                    old_cur;
    logic [CNT_W-1:0]                    new_cur;
    logic signed [macd_pkg::DIFF_W-1:0]  x_cur;
    logic signed [macd_pkg::DIFF_W-1:0]  avg_cur;
    logic signed [macd_pkg::SIG_SUM_W-1:0] sum_cur;
    logic signed [macd_pkg::SIG_SUM_W-1:0] sum_new;
    logic [macd_pkg::SIG_SUM_W-1:0]      sum_mag;
    logic signed [macd_pkg::DIFF_W-1:0]  diff;
    logic signed [macd_pkg::ALPHA_W:0]   alpha_s;
    logic signed [macd_pkg::DIFF_W-1:0]  avg_upd;
    logic                                per_zero;
    logic                                in_update;
    logic                                seeding;
    logic                                alpha_hit;
    logic                                out_free;

    // divider step
    logic [macd_pkg::DEN_W:0]            rem_sh;
    logic [macd_pkg::DEN_W:0]            rem_sub;
    logic                                rem_ge;
    logic signed [macd_pkg::SIG_SUM_W-1:0] quot_s;
    logic signed [macd_pkg::SIG_SUM_W-1:0] seed_val;

    assign sel_idx = sel_reg;

    always_comb
    begin
        unique case (sel_reg)
            macd_pkg::AVG_FAST:
            begin
                p_cur   = fast_period_reg;
                old_cur = bar_old_reg;
                x_cur   = $signed({3'b000, close_reg});
                avg_cur = $signed({3'b000, fast_avg_reg});
                sum_cur = $signed({2'b00, fast_sum_reg});
            end
            macd_pkg::AVG_SLOW:
            begin
                p_cur   = slow_period_reg;
                old_cur = bar_old_reg;
                x_cur   = $signed({3'b000, close_reg});
                avg_cur = $signed({3'b000, slow_avg_reg});
                sum_cur = $signed({2'b00, slow_sum_reg});
            end
            macd_pkg::AVG_SIGNAL:
            begin
                p_cur   = signal_period_reg;
                old_cur = macd_cnt_reg;
                x_cur   = {{2{macd_reg[macd_pkg::MACD_W-1]}}, macd_reg};
                avg_cur = {sig_avg_reg[macd_pkg::SIG_AVG_W-1], sig_avg_reg};
                sum_cur = sig_sum_reg;
            end
            default:
            begin
                p_cur   = '0;
                old_cur = '0;
                x_cur   = '0;
                avg_cur = '0;
                sum_cur = '0;
            end
        endcase
    end

    assign new_cur   = (old_cur < CNT_MAX) ? old_cur + CNT_W'(1) : old_cur;
    assign per_zero  = (p_cur == '0);
    assign in_update = !per_zero && (CMP_W'(old_cur) >= CMP_W'(p_cur));
    assign seeding   = !per_zero && !in_update && (CMP_W'(new_cur) == CMP_W'(p_cur));
    assign alpha_hit = alpha_ok_reg[sel_idx] && (alpha_period_reg[sel_idx] == p_cur);

    assign sum_new = sum_cur + {{(macd_pkg::SIG_SUM_W - macd_pkg::DIFF_W){x_cur[macd_pkg::DIFF_W-1]}},
                                x_cur};
    assign sum_mag = sum_new[macd_pkg::SIG_SUM_W-1] ? -sum_new : sum_new;

    assign diff    = x_cur - avg_cur;
    assign alpha_s = $signed({1'b0, alpha_reg[sel_idx]});
    assign avg_upd = avg_cur + prod_reg[macd_pkg::ALPHA_SHIFT+macd_pkg::DIFF_W-1:macd_pkg::ALPHA_SHIFT];

    assign rem_sh  = {div_rem_reg, div_num_reg[macd_pkg::DIV_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, div_den_reg});
    assign rem_sub = rem_sh - {1'b0, div_den_reg};
    assign quot_s  = $signed({1'b0, div_num_reg});
    assign seed_val = div_neg_reg ? -quot_s : quot_s;

    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            macd_pkg::ST_IDLE:
                if (bar.valid)
                    state_next = macd_pkg::ST_SETUP;
            macd_pkg::ST_SETUP:
                if (in_update)
                    state_next = alpha_hit ? macd_pkg::ST_MUL : macd_pkg::ST_DIV;
                else if (seeding)
                    state_next = macd_pkg::ST_DIV;
                else
                    state_next = macd_pkg::ST_NEXT;
            macd_pkg::ST_DIV:
                if (div_cnt_reg == '0)
                    state_next = macd_pkg::ST_DIVEND;
            macd_pkg::ST_DIVEND:
                state_next = div_alpha_reg ? macd_pkg::ST_MUL : macd_pkg::ST_NEXT;
            macd_pkg::ST_MUL:
                state_next = macd_pkg::ST_ADD;
            macd_pkg::ST_ADD:
                state_next = macd_pkg::ST_NEXT;
            macd_pkg::ST_NEXT:
                if (sel_reg == macd_pkg::AVG_FAST)
                    state_next = macd_pkg::ST_SETUP;
                else if (sel_reg == macd_pkg::AVG_SLOW && fast_ok_reg && slow_ok_reg)
                    state_next = macd_pkg::ST_SETUP;
                else
                    state_next = macd_pkg::ST_FIN;
            macd_pkg::ST_FIN:
                if (out_free)
                    state_next = macd_pkg::ST_IDLE;
            default:
                state_next = macd_pkg::ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_period_reg   <= macd_pkg::FAST_PERIOD_RESET;
            slow_period_reg   <= macd_pkg::SLOW_PERIOD_RESET;
            signal_period_reg <= macd_pkg::SIGNAL_PERIOD_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                macd_pkg::CFG_FAST_PERIOD:   fast_period_reg   <= cfg_data;
                macd_pkg::CFG_SLOW_PERIOD:   slow_period_reg   <= cfg_data;
                macd_pkg::CFG_SIGNAL_PERIOD: signal_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= macd_pkg::ST_IDLE;
            sel_reg       <= macd_pkg::AVG_FAST;
            fast_avg_reg  <= '0;
            slow_avg_reg  <= '0;
            fast_sum_reg  <= '0;
            slow_sum_reg  <= '0;
            sig_avg_reg   <= '0;
            sig_sum_reg   <= '0;
            bar_cnt_reg   <= '0;
            bar_old_reg   <= '0;
            macd_cnt_reg  <= '0;
            macd_reg      <= '0;
            fast_ok_reg   <= 1'b0;
            slow_ok_reg   <= 1'b0;
            sig_ok_reg    <= 1'b0;
            alpha_ok_reg  <= '0;
            div_alpha_reg <= 1'b0;
            div_neg_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            unique case (state_reg)
                macd_pkg::ST_IDLE:
                    if (bar.valid)
                    begin
                        close_reg   <= bar.close_price;
                        sel_reg     <= macd_pkg::AVG_FAST;
                        fast_ok_reg <= 1'b0;
                        slow_ok_reg <= 1'b0;
                        sig_ok_reg  <= 1'b0;
                        if (bar.series_start)
                        begin
                            fast_avg_reg <= '0;
                            slow_avg_reg <= '0;
                            fast_sum_reg <= '0;
                            slow_sum_reg <= '0;
                            sig_avg_reg  <= '0;
                            sig_sum_reg  <= '0;
                            macd_cnt_reg <= '0;
                            bar_old_reg  <= '0;
                            bar_cnt_reg  <= (CNT_MAX > '0) ? CNT_W'(1) : '0;
                        end
                        else
                        begin
                            bar_old_reg <= bar_cnt_reg;
                            bar_cnt_reg <= (bar_cnt_reg < CNT_MAX) ?
                                           bar_cnt_reg + CNT_W'(1) : bar_cnt_reg;
                        end
                    end
                macd_pkg::ST_SETUP:
                begin
                    if (sel_reg == macd_pkg::AVG_SIGNAL)
                        macd_cnt_reg <= new_cur;
                    if (!per_zero && !in_update)
                    begin
                        unique case (sel_reg)
                            macd_pkg::AVG_FAST:   fast_sum_reg <= sum_new[macd_pkg::SUM_W-1:0];
                            macd_pkg::AVG_SLOW:   slow_sum_reg <= sum_new[macd_pkg::SUM_W-1:0];
                            macd_pkg::AVG_SIGNAL: sig_sum_reg  <= sum_new;
                            default: ;
                        endcase
                    end
                    unique case (sel_reg)
                        macd_pkg::AVG_FAST:   fast_ok_reg <= in_update || seeding;
                        macd_pkg::AVG_SLOW:   slow_ok_reg <= in_update || seeding;
                        macd_pkg::AVG_SIGNAL: sig_ok_reg  <= in_update || seeding;
                        default: ;
                    endcase
                    div_rem_reg <= '0;
                    div_cnt_reg <= macd_pkg::DIV_CNT_W'(macd_pkg::DIV_W - 1);
                    if (in_update)
                    begin
                        div_alpha_reg <= 1'b1;
                        div_neg_reg   <= 1'b0;
                        div_num_reg   <= macd_pkg::ALPHA_NUM;
                        div_den_reg   <= macd_pkg::DEN_W'(p_cur) + macd_pkg::DEN_W'(1);
                    end
                    else
                    begin
                        div_alpha_reg <= 1'b0;
                        div_neg_reg   <= sum_new[macd_pkg::SIG_SUM_W-1];
                        div_num_reg   <= sum_mag[macd_pkg::DIV_W-1:0];
                        div_den_reg   <= macd_pkg::DEN_W'(p_cur);
                    end
                end
                macd_pkg::ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg - macd_pkg::DIV_CNT_W'(1);
                    div_rem_reg <= rem_ge ? rem_sub[macd_pkg::DEN_W-1:0] :
                                            rem_sh[macd_pkg::DEN_W-1:0];
                    div_num_reg <= {div_num_reg[macd_pkg::DIV_W-2:0], rem_ge};
                end
                macd_pkg::ST_DIVEND:
                    if (div_alpha_reg)
                    begin
                        alpha_reg[sel_idx]        <= div_num_reg[macd_pkg::ALPHA_W-1:0];
                        alpha_period_reg[sel_idx] <= p_cur;
                        alpha_ok_reg[sel_idx]     <= 1'b1;
                    end
                    else
                    begin
                        unique case (sel_reg)
                            macd_pkg::AVG_FAST:
                                fast_avg_reg <= seed_val[macd_pkg::PRICE_W-1:0];
                            macd_pkg::AVG_SLOW:
                                slow_avg_reg <= seed_val[macd_pkg::PRICE_W-1:0];
                            macd_pkg::AVG_SIGNAL:
                                sig_avg_reg  <= seed_val[macd_pkg::SIG_AVG_W-1:0];
                            default: ;
                        endcase
                    end
                macd_pkg::ST_MUL:
                    prod_reg <= macd_pkg::PROD_W'(diff) * macd_pkg::PROD_W'(alpha_s);
                macd_pkg::ST_ADD:
                begin
                    unique case (sel_reg)
                        macd_pkg::AVG_FAST:   fast_avg_reg <= avg_upd[macd_pkg::PRICE_W-1:0];
                        macd_pkg::AVG_SLOW:   slow_avg_reg <= avg_upd[macd_pkg::PRICE_W-1:0];
                        macd_pkg::AVG_SIGNAL: sig_avg_reg  <= avg_upd[macd_pkg::SIG_AVG_W-1:0];
                        default: ;
                    endcase
                end
                macd_pkg::ST_NEXT:
                begin
                    if (sel_reg == macd_pkg::AVG_FAST)
                        sel_reg <= macd_pkg::AVG_SLOW;
                    else if (sel_reg == macd_pkg::AVG_SLOW)
                    begin
                        sel_reg  <= macd_pkg::AVG_SIGNAL;
                        macd_reg <= $signed({1'b0, fast_avg_reg}) - $signed({1'b0, slow_avg_reg});
                    end
                end
                macd_pkg::ST_FIN:
                    if (out_free)
                    begin
                        out_macd_valid_reg   <= fast_ok_reg && slow_ok_reg;
                        out_signal_valid_reg <= sig_ok_reg;
                        out_macd_reg         <= (fast_ok_reg && slow_ok_reg) ? macd_reg : '0;
                        out_signal_reg       <= sig_ok_reg ?
                                                sig_avg_reg[macd_pkg::MACD_W-1:0] : '0;
                        out_hist_reg         <= sig_ok_reg ?
                            ({macd_reg[macd_pkg::MACD_W-1], macd_reg} -
                             {sig_avg_reg[macd_pkg::MACD_W-1], sig_avg_reg[macd_pkg::MACD_W-1:0]})
                            : '0;
                    end
                default: ;
            endcase

            if (state_reg == macd_pkg::ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign bar.ready              = (state_reg == macd_pkg::ST_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.macd_valid      = out_macd_valid_reg;
    assign result.macd_value      = out_macd_reg;
    assign result.signal_valid    = out_signal_valid_reg;
    assign result.signal_value    = out_signal_reg;
    assign result.histogram_value = out_hist_reg;

endmodule

`default_nettype wire
